/* sv/double_ended_queue_macros.svh */
// ----------------------------------------------------------------------------
// double_ended_queue_macros
// Assertion macros shared by the deque modules; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every clock edge outside reset
`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset
`define DEQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DEQ_ASSERT(label, clk, rst_n, prop, msg)
`define DEQ_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* sv/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Operation codes, controller states and command group for the deque.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int FUNC_W = 3;

	// Operation codes carried in func
	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_FILL
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic start;   // item accepted: update pointers, issue memory access
		logic finish;  // load the result register
	} deq_cmd_t;

endpackage

/* sv/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl
// Two-state controller: accept an item, then load the result register once
// the output side has room.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output deq_pkg::deq_cmd_t cmd
);

	deq_pkg::state_t state_q, state_nxt;
	logic out_valid_q;

	// State register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt  = state_q;
		in_ready   = 1'b0;
		cmd.start  = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			deq_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
				if (in_valid) begin
					state_nxt = deq_pkg::ST_FILL;
				end
			end
			deq_pkg::ST_FILL: begin
				// hold until the result register is free or being taken
				cmd.finish = !out_valid_q || out_ready;
				if (cmd.finish) begin
					state_nxt = deq_pkg::ST_IDLE;
				end
			end
			default: state_nxt = deq_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`DEQ_ASSERT(a_start_to_fill, clk, arst_n, cmd.start |=> state_q == deq_pkg::ST_FILL, "accepted item did not move to fill")
	`DEQ_ASSERT(a_fill_stall, clk, arst_n, (state_q == deq_pkg::ST_FILL && out_valid_q && !out_ready) |=> (state_q == deq_pkg::ST_FILL && out_valid_q), "result overwritten while stalled")

endmodule

/* sv/deq_datapath.sv */
// ----------------------------------------------------------------------------
// deq_datapath
// Ring buffer with head and tail pointers, cached front and back values and
// the result register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module deq_datapath #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 17,
	parameter int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  deq_pkg::deq_cmd_t           cmd,
	input  logic [deq_pkg::FUNC_W-1:0]  func,
	input  logic [VALUE_BITS-1:0]       value,
	output logic signed [VALUE_BITS:0]  popped,
	output logic [CNT_W-1:0]            count,
	output logic                        is_empty,
	output logic signed [VALUE_BITS:0]  front_value,
	output logic signed [VALUE_BITS:0]  back_value,
	output logic                        overflow
);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [VALUE_BITS:0] NEG_ONE = '1;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : p - PTR_W'(1);
	endfunction

	logic [VALUE_BITS-1:0] mem [CAPACITY];
	logic [VALUE_BITS-1:0] rd_data_q;

	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [VALUE_BITS-1:0] front_q, back_q;
	logic [VALUE_BITS:0] popped_q;
	logic ovf_q, load_front_q, load_back_q;

	logic push_f, push_b, pop_f, pop_b, full, nonempty, refill;
	logic [PTR_W-1:0] head_prev, head_next, tail_prev, tail_prev2;
	logic mem_we, mem_re;
	logic [PTR_W-1:0] mem_waddr, mem_raddr;
	logic [VALUE_BITS-1:0] front_nxt, back_nxt;

	// Decode the operation
	always_comb begin
		push_f = 1'b0;
		push_b = 1'b0;
		pop_f  = 1'b0;
		pop_b  = 1'b0;
		unique case (func)
			deq_pkg::FUNC_PUSH_FRONT: push_f = 1'b1;
			deq_pkg::FUNC_PUSH_BACK:  push_b = 1'b1;
			deq_pkg::FUNC_POP_FRONT:  pop_f  = 1'b1;
			deq_pkg::FUNC_POP_BACK:   pop_b  = 1'b1;
			default: ;  // query and unused codes change nothing
		endcase
	end

	assign full       = (count_q == CNT_FULL);
	assign nonempty   = (count_q != '0);
	assign refill     = (count_q > CNT_ONE);  // an element remains after a pop
	assign head_prev  = ring_prev(head_q);
	assign head_next  = ring_next(head_q);
	assign tail_prev  = ring_prev(tail_q);
	assign tail_prev2 = ring_prev(tail_prev);

	assign mem_we    = cmd.start && (push_f || push_b) && !full;
	assign mem_waddr = push_f ? head_prev : tail_q;
	assign mem_re    = cmd.start && (pop_f || pop_b) && refill;
	assign mem_raddr = pop_f ? head_next : tail_prev2;

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= value;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// Pointers, count and pending reloads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			load_front_q <= 1'b0;
			load_back_q  <= 1'b0;
		end else if (cmd.start) begin
			ovf_q        <= (push_f || push_b) && full;
			load_front_q <= pop_f && refill;
			load_back_q  <= pop_b && refill;
			if (push_f && !full) begin
				head_q  <= head_prev;
				count_q <= count_q + CNT_ONE;
			end else if (push_b && !full) begin
				tail_q  <= ring_next(tail_q);
				count_q <= count_q + CNT_ONE;
			end else if (pop_f && nonempty) begin
				head_q  <= head_next;
				count_q <= count_q - CNT_ONE;
			end else if (pop_b && nonempty) begin
				tail_q  <= tail_prev;
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	// Cached end values and popped value
	assign front_nxt = load_front_q ? rd_data_q : front_q;
	assign back_nxt  = load_back_q ? rd_data_q : back_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (pop_f && nonempty) begin
				popped_q <= {1'b0, front_q};
			end else if (pop_b && nonempty) begin
				popped_q <= {1'b0, back_q};
			end else begin
				popped_q <= NEG_ONE;
			end
			if (push_f && !full) begin
				front_q <= value;
				if (!nonempty) begin
					back_q <= value;
				end
			end else if (push_b && !full) begin
				back_q <= value;
				if (!nonempty) begin
					front_q <= value;
				end
			end
		end else if (cmd.finish) begin
			front_q <= front_nxt;
			back_q  <= back_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			popped      <= popped_q;
			count       <= count_q;
			is_empty    <= !nonempty;
			front_value <= nonempty ? {1'b0, front_nxt} : NEG_ONE;
			back_value  <= nonempty ? {1'b0, back_nxt} : NEG_ONE;
			overflow    <= ovf_q;
		end
	end

	`DEQ_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_FULL, "count beyond capacity")
	`DEQ_ASSERT(a_pop_count, clk, arst_n, (cmd.start && (pop_f || pop_b) && nonempty) |=> count_q == $past(count_q) - CNT_ONE, "pop did not decrement count")
	`DEQ_ASSERT_NEVER(a_empty_ptrs, clk, arst_n, count_q == '0 && head_q != tail_q, "empty queue with unequal pointers")

endmodule

/* sv/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of values held in a ring buffer, one result per item.
// ----------------------------------------------------------------------------
// Each item pushes at the front or back, pops from the front or back, or
// queries; every item gives exactly one result with the popped value (-1 if
// none), the count, an empty flag, the front and back values (-1 when empty)
// and an overflow flag for a push dropped on a full queue. The accept cycle
// updates the pointers and starts a read of the slot memory, and the fill
// state then takes the registered read data (the new front or back after a
// pop) into the result register. The next item is accepted while a
// finished result still waits; it then holds in the fill state until the
// result register is free. No clearing pass after reset: slots are only read
// once written.
// ----------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
	parameter int CAPACITY   = 1024,
	parameter int VALUE_BITS = 17
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [deq_pkg::FUNC_W-1:0]           func,
	input  logic [VALUE_BITS-1:0]                value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [VALUE_BITS:0]           popped,
	output logic [$clog2(CAPACITY + 1)-1:0]      count,
	output logic                                 is_empty,
	output logic signed [VALUE_BITS:0]           front_value,
	output logic signed [VALUE_BITS:0]           back_value,
	output logic                                 overflow
);

	deq_pkg::deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	deq_datapath #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.value       (value),
		.popped      (popped),
		.count       (count),
		.is_empty    (is_empty),
		.front_value (front_value),
		.back_value  (back_value),
		.overflow    (overflow)
	);

endmodule
